### hw/rtl/gap_buffer_text_editor_core_macros.svh
// Assertion macros shared by the gap buffer editor RTL.
// Needs nothing else; included by the files that carry checks.
`ifndef GAP_BUFFER_TEXT_EDITOR_CORE_MACROS_SVH
`define GAP_BUFFER_TEXT_EDITOR_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define GBTE_ASSERT_IMPLY(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("gbte: same-cycle check failed");

// next-cycle implication, off during reset
`define GBTE_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("gbte: next-cycle check failed");

`endif

### hw/rtl/gbte_pkg.sv
// Shared constants, types and helpers of the gap buffer editor.
// No dependencies; imported by gbte_gap and the top level.
package gbte_pkg;

  localparam int BUF_LEN = 64;
  localparam int AW      = $clog2(BUF_LEN);
  localparam int POS_W   = 6;
  localparam int CW      = (AW > POS_W) ? AW : POS_W;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 48;

  localparam logic [AW-1:0] GAP_TOP = AW'(BUF_LEN - 1);

  typedef enum logic [2:0] {
    FN_INSERT    = 3'd0,
    FN_BACK      = 3'd1,
    FN_LEFT      = 3'd2,
    FN_RIGHT     = 3'd3,
    FN_SEL_LEFT  = 3'd4,
    FN_SEL_RIGHT = 3'd5,
    FN_DESELECT  = 3'd6,
    FN_GOTO      = 3'd7
  } gbte_func_t;

  typedef enum logic [1:0] {
    PR_INSERT = 2'd0,
    PR_BACK   = 2'd1,
    PR_LEFT   = 2'd2,
    PR_RIGHT  = 2'd3
  } gbte_prim_t;

  typedef struct packed {
    logic       valid;
    gbte_prim_t op;
    logic [7:0] ch;
  } gbte_req_t;

  typedef struct packed {
    logic [AW-1:0] gs;
    logic [AW-1:0] ge;
    logic [7:0]    cb;
    logic [7:0]    ca;
    logic          ok;
  } gbte_view_t;

  function automatic logic [POS_W-1:0] pos_out(input logic [AW-1:0] v);
    logic [AW+POS_W-1:0] w;
    w = {{POS_W{1'b0}}, v};
    return w[POS_W-1:0];
  endfunction

  function automatic logic [CW-1:0] pos_ext(input logic [AW-1:0] v);
    logic [AW+CW-1:0] w;
    w = {{CW{1'b0}}, v};
    return w[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] tgt_ext(input logic [POS_W-1:0] v);
    logic [POS_W+CW-1:0] w;
    w = {{CW{1'b0}}, v};
    return w[CW-1:0];
  endfunction

endpackage

### hw/rtl/gap_buffer_text_editor_core.sv
// Gap buffer text editor core: takes one edit or cursor command per input beat
// and returns one status beat with the cursor, text length, the bytes on either
// side of the gap and the selection. Each command moves from idle to the wait
// state, which loads its status beat, or on to the hold state while the output
// register is full; the input is ready again in idle after the load. Goto stays
// in the wait state, moving the gap one position at a time, since the single
// write port of the text store copies one byte across the gap per cycle. The
// store needs no clearing pass after reset: only bytes already written are ever
// shown. A new command is taken while the last result still waits on the output
// register; its own beat then holds until that register is free.
// Depends on gbte_pkg and gbte_gap.
module gap_buffer_text_editor_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // func[2:0], char_in[10:3], target_index[16:11], zero[23:17]
  input  logic [gbte_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // moved[0], cursor[6:1], text_length[12:7], char_before[20:13],
  // char_after[28:21], sel_active[29], sel_start[35:30], sel_end[41:36], zero[47:42]
  output logic [gbte_pkg::OUT_W-1:0] m_axis_tdata
);
  import gbte_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_HOLD
  } state_t;

  state_t            state;
  gbte_func_t        func_q, in_fn;
  logic [POS_W-1:0]  tgt_q, in_tgt;
  logic [7:0]        in_ch;
  logic              moved_q, mv;
  logic              sel_on, sel_on_next;
  logic [AW-1:0]     sel_first, sel_first_next;
  logic [AW-1:0]     sel_last, sel_last_next;
  logic              accept, is_sel, step_left, step_right, goto_step;
  logic              finish, load;
  logic [AW-1:0]     len;
  logic [OUT_W-1:0]  out_word;
  gbte_req_t         req;
  gbte_view_t        view;

  gbte_gap u_gap (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .view (view)
  );

  always_comb begin
    in_fn         = gbte_func_t'(s_axis_tdata[2:0]);
    in_ch         = s_axis_tdata[10:3];
    in_tgt        = s_axis_tdata[16:11];
    s_axis_tready = (state == S_IDLE);
    accept        = s_axis_tvalid && s_axis_tready;

    step_left  = pos_ext(view.gs) > tgt_ext(tgt_q);
    step_right = (pos_ext(view.gs) < tgt_ext(tgt_q)) && (view.ge != GAP_TOP);
    goto_step  = (state == S_WAIT) && (func_q == FN_GOTO) && (step_left || step_right);

    req.valid = 1'b0;
    req.op    = PR_INSERT;
    req.ch    = in_ch;
    if (accept) begin
      unique case (in_fn) inside
        FN_INSERT: begin
          req.valid = 1'b1;
          req.op    = PR_INSERT;
        end
        FN_BACK: begin
          req.valid = 1'b1;
          req.op    = PR_BACK;
        end
        FN_LEFT, FN_SEL_LEFT: begin
          req.valid = 1'b1;
          req.op    = PR_LEFT;
        end
        FN_RIGHT, FN_SEL_RIGHT: begin
          req.valid = 1'b1;
          req.op    = PR_RIGHT;
        end
        default: req.valid = 1'b0;
      endcase
    end else if (goto_step) begin
      req.valid = 1'b1;
      req.op    = step_left ? PR_LEFT : PR_RIGHT;
    end

    is_sel         = (func_q == FN_SEL_LEFT) || (func_q == FN_SEL_RIGHT);
    sel_on_next    = sel_on;
    sel_first_next = sel_first;
    sel_last_next  = sel_last;
    if (accept) begin
      if (in_fn == FN_DESELECT) begin
        sel_on_next = 1'b0;
      end
      if ((in_fn == FN_SEL_LEFT || in_fn == FN_SEL_RIGHT) && !sel_on) begin
        sel_on_next    = 1'b1;
        sel_first_next = view.gs;
        sel_last_next  = view.gs;
      end
    end
    if (state == S_WAIT && is_sel) begin
      if (view.ok) begin
        if (func_q == FN_SEL_LEFT) begin
          if (view.gs < sel_first) begin
            sel_first_next = sel_first - AW'(1);
          end else begin
            sel_last_next = sel_last - AW'(1);
          end
        end else begin
          if (view.gs >= sel_first && view.gs > sel_last) begin
            sel_last_next = sel_last + AW'(1);
          end else begin
            sel_first_next = sel_first + AW'(1);
          end
        end
      end
      sel_on_next = (sel_first_next != sel_last_next);
    end

    if (state == S_WAIT) begin
      if (func_q == FN_GOTO) begin
        mv = moved_q;
      end else if (func_q == FN_DESELECT) begin
        mv = 1'b0;
      end else begin
        mv = view.ok;
      end
    end else begin
      mv = moved_q;
    end

    finish   = ((state == S_WAIT) && !goto_step) || (state == S_HOLD);
    load     = finish && (!m_axis_tvalid || m_axis_tready);
    len      = view.gs + (GAP_TOP - view.ge);
    out_word = {{(OUT_W - 42){1'b0}},
                pos_out(sel_last_next), pos_out(sel_first_next), sel_on_next,
                view.ca, view.cb, pos_out(len), pos_out(view.gs), mv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sel_on        <= 1'b0;
      sel_first     <= '0;
      sel_last      <= '0;
      moved_q       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= out_word;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      sel_on    <= sel_on_next;
      sel_first <= sel_first_next;
      sel_last  <= sel_last_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            func_q  <= in_fn;
            tgt_q   <= in_tgt;
            moved_q <= 1'b0;
            state   <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (goto_step) begin
            moved_q <= 1'b1;
          end else begin
            moved_q <= mv;
            state   <= load ? S_IDLE : S_HOLD;
          end
        end
        S_HOLD: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/gbte_gap.sv
// Gap buffer store: text memory, gap pointers and the bytes beside the gap.
// Depends on gbte_pkg and the assertion macro header.
`include "gap_buffer_text_editor_core_macros.svh"

module gbte_gap (
  input  logic                clk,
  input  logic                rst,
  input  gbte_pkg::gbte_req_t req,
  output gbte_pkg::gbte_view_t view
);
  import gbte_pkg::*;

  typedef enum logic [1:0] {
    PD_NONE,
    PD_CB,
    PD_CA
  } pend_t;

  logic [7:0]    mem [BUF_LEN];
  logic [7:0]    rdata;
  logic [AW-1:0] gs, gs_next;
  logic [AW-1:0] ge, ge_next;
  logic [7:0]    cb, cb_next, cb_e;
  logic [7:0]    ca, ca_next, ca_e;
  logic          ok, ok_next;
  pend_t         pend, pend_next;
  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [7:0]    wd;

  always_comb begin
    cb_e      = (pend == PD_CB) ? rdata : cb;
    ca_e      = (pend == PD_CA) ? rdata : ca;
    gs_next   = gs;
    ge_next   = ge;
    cb_next   = cb_e;
    ca_next   = ca_e;
    ok_next   = ok;
    pend_next = PD_NONE;
    we        = 1'b0;
    wa        = gs;
    wd        = req.ch;
    re        = 1'b0;
    ra        = gs - AW'(2);
    if (req.valid) begin
      unique case (req.op)
        PR_INSERT: begin
          ok_next = (gs != ge);
          if (ok_next) begin
            we      = 1'b1;
            wa      = gs;
            wd      = req.ch;
            gs_next = gs + AW'(1);
            cb_next = req.ch;
          end
        end
        PR_BACK, PR_LEFT: begin
          ok_next = (gs != '0);
          if (ok_next) begin
            gs_next = gs - AW'(1);
            if (req.op == PR_LEFT) begin
              we      = 1'b1;
              wa      = ge;
              wd      = cb_e;
              ca_next = cb_e;
              ge_next = ge - AW'(1);
            end
            if (gs_next == '0) begin
              cb_next = '0;
            end else begin
              re        = 1'b1;
              ra        = gs - AW'(2);
              pend_next = PD_CB;
            end
          end
        end
        PR_RIGHT: begin
          ok_next = (ge != GAP_TOP);
          if (ok_next) begin
            we      = 1'b1;
            wa      = gs;
            wd      = ca_e;
            cb_next = ca_e;
            gs_next = gs + AW'(1);
            ge_next = ge + AW'(1);
            if (ge_next == GAP_TOP) begin
              ca_next = '0;
            end else begin
              re        = 1'b1;
              ra        = ge + AW'(2);
              pend_next = PD_CA;
            end
          end
        end
        default: ok_next = ok;
      endcase
    end
    view.gs = gs;
    view.ge = ge;
    view.cb = cb_e;
    view.ca = ca_e;
    view.ok = ok;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gs   <= '0;
      ge   <= GAP_TOP;
      cb   <= '0;
      ca   <= '0;
      ok   <= 1'b0;
      pend <= PD_NONE;
    end else begin
      gs   <= gs_next;
      ge   <= ge_next;
      cb   <= cb_next;
      ca   <= ca_next;
      ok   <= ok_next;
      pend <= pend_next;
    end
  end

  `GBTE_ASSERT_IMPLY(a_gap_order, clk, rst, 1'b1, gs <= ge)
  `GBTE_ASSERT_IMPLY(a_rw_apart, clk, rst, we && re, wa != ra)
  `GBTE_ASSERT_NEXT(a_read_used, clk, rst, re, pend != PD_NONE)
  `GBTE_ASSERT_NEXT(a_ins_before, clk, rst,
    req.valid && req.op == PR_INSERT && gs != ge, cb == $past(req.ch))

endmodule

### tb/gap_buffer_text_editor_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for gap_buffer_text_editor_core: a directed command script, then
// biased random commands, each status beat checked against an in-bench gap buffer model
// or, for the typed script rows, a hand-written expected beat. Depends on gbte_pkg and the core RTL only.
module gap_buffer_text_editor_core_tb;
  import gbte_pkg::*;

  localparam int DEPTH      = gbte_pkg::BUF_LEN;
  localparam int N_RANDOM   = 1150;
  localparam int N_SCRIPT   = 27;
  localparam int DRAIN_CYC  = 100;
  localparam int CYCLE_CAP  = 1500000;

  // same bit order as m_axis_tdata, moved in the lowest bit
  typedef struct packed {
    logic [5:0] sel_end;
    logic [5:0] sel_start;
    logic       sel_active;
    logic [7:0] ch_after;
    logic [7:0] ch_before;
    logic [5:0] text_len;
    logic [5:0] cursor;
    logic       moved;
  } status_t;

  typedef struct {
    gbte_func_t fn;
    logic [7:0] ch;
    logic [5:0] tgt;
    int         reps;
    bit         typed;
    status_t    want;
  } script_row_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;

  // editor model state
  logic [7:0]  text_mem [DEPTH];
  int unsigned gap_lo;
  int unsigned gap_hi;
  bit          sel_on;
  logic [31:0] sel_from;
  logic [31:0] sel_to;

  status_t     status_q [$];
  int          errors;
  int          cycles;
  bit          tx_steady;
  bit          rx_steady;
  int          rx_stall;

  script_row_t script [N_SCRIPT] = '{
    '{FN_LEFT,      8'h00, 6'd0,  1,  1'b1, '0},
    '{FN_BACK,      8'h00, 6'd0,  1,  1'b1, '0},
    '{FN_RIGHT,     8'h00, 6'd0,  1,  1'b1, '0},
    '{FN_SEL_LEFT,  8'h00, 6'd0,  1,  1'b1, '0},
    '{FN_GOTO,      8'h00, 6'd63, 1,  1'b1, '0},
    '{FN_INSERT,    8'hFF, 6'd0,  1,  1'b1, '{6'd0, 6'd0, 1'b0, 8'h00, 8'hFF, 6'd1, 6'd1, 1'b1}},
    '{FN_INSERT,    8'h00, 6'd0,  1,  1'b1, '{6'd0, 6'd0, 1'b0, 8'h00, 8'h00, 6'd2, 6'd2, 1'b1}},
    '{FN_INSERT,    8'hA5, 6'd0,  1,  1'b0, '0},
    '{FN_SEL_LEFT,  8'h00, 6'd0,  2,  1'b0, '0},
    '{FN_SEL_RIGHT, 8'h00, 6'd0,  1,  1'b0, '0},
    '{FN_DESELECT,  8'h00, 6'd0,  1,  1'b0, '0},
    '{FN_SEL_RIGHT, 8'h00, 6'd0,  2,  1'b0, '0},
    '{FN_GOTO,      8'h00, 6'd0,  1,  1'b0, '0},
    '{FN_GOTO,      8'h00, 6'd63, 1,  1'b0, '0},
    '{FN_LEFT,      8'h00, 6'd0,  2,  1'b0, '0},
    '{FN_BACK,      8'h00, 6'd0,  1,  1'b0, '0},
    '{FN_INSERT,    8'h5A, 6'd0,  70, 1'b0, '0},
    '{FN_GOTO,      8'h00, 6'd63, 1,  1'b0, '0},
    '{FN_RIGHT,     8'h00, 6'd0,  1,  1'b0, '0},
    '{FN_GOTO,      8'h00, 6'd0,  1,  1'b0, '0},
    '{FN_LEFT,      8'h00, 6'd0,  1,  1'b0, '0},
    '{FN_SEL_RIGHT, 8'h00, 6'd0,  2,  1'b0, '0},
    '{FN_SEL_LEFT,  8'h00, 6'd0,  3,  1'b0, '0},
    '{FN_DESELECT,  8'h00, 6'd0,  1,  1'b0, '0},
    '{FN_GOTO,      8'h00, 6'd32, 1,  1'b0, '0},
    '{FN_BACK,      8'h00, 6'd0,  3,  1'b0, '0},
    '{FN_INSERT,    8'h81, 6'd0,  1,  1'b0, '0}
  };

  gap_buffer_text_editor_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic void clear_editor();
    foreach (text_mem[i]) text_mem[i] = 8'h00;
    gap_lo   = 0;
    gap_hi   = DEPTH - 1;
    sel_on   = 1'b0;
    sel_from = '0;
    sel_to   = '0;
  endfunction

  function automatic bit swap_left();
    logic [7:0] t;
    if (gap_lo == 0) return 1'b0;
    t                  = text_mem[gap_hi];
    text_mem[gap_hi]   = text_mem[gap_lo-1];
    text_mem[gap_lo-1] = t;
    gap_lo--;
    gap_hi--;
    return 1'b1;
  endfunction

  function automatic bit swap_right();
    logic [7:0] t;
    if (gap_hi >= DEPTH - 1) return 1'b0;
    t                  = text_mem[gap_hi+1];
    text_mem[gap_hi+1] = text_mem[gap_lo];
    text_mem[gap_lo]   = t;
    gap_lo++;
    gap_hi++;
    return 1'b1;
  endfunction

  function automatic bit extend_selection(bit to_left);
    bit ok;
    if (!sel_on) begin
      sel_from = gap_lo;
      sel_to   = gap_lo;
      sel_on   = 1'b1;
    end
    ok = to_left ? swap_left() : swap_right();
    if (ok) begin
      if (to_left) begin
        if (gap_lo < sel_from) sel_from = sel_from - 1;
        else sel_to = sel_to - 1;
      end else begin
        if (gap_lo >= sel_from && gap_lo > sel_to) sel_to = sel_to + 1;
        else sel_from = sel_from + 1;
      end
    end
    if (sel_from == sel_to) sel_on = 1'b0;
    return ok;
  endfunction

  function automatic status_t apply_command(gbte_func_t fn, logic [7:0] ch, logic [5:0] tgt);
    status_t     s;
    bit          ok;
    int unsigned start_pos;
    ok = 1'b0;
    case (fn)
      FN_INSERT: begin
        if (gap_lo != gap_hi) begin
          text_mem[gap_lo] = ch;
          gap_lo++;
          ok = 1'b1;
        end
      end
      FN_BACK: begin
        if (gap_lo != 0) begin
          gap_lo--;
          text_mem[gap_lo] = 8'h00;
          ok = 1'b1;
        end
      end
      FN_LEFT:      ok = swap_left();
      FN_RIGHT:     ok = swap_right();
      FN_SEL_LEFT:  ok = extend_selection(1'b1);
      FN_SEL_RIGHT: ok = extend_selection(1'b0);
      FN_DESELECT:  sel_on = 1'b0;
      default: begin
        start_pos = gap_lo;
        while (gap_lo > tgt) void'(swap_left());
        while (gap_lo < tgt && swap_right()) ;
        ok = (gap_lo != start_pos);
      end
    endcase
    s.moved      = ok;
    s.cursor     = 6'(gap_lo);
    s.text_len   = 6'(gap_lo + (DEPTH - 1 - gap_hi));
    s.ch_before  = (gap_lo > 0) ? text_mem[gap_lo-1] : 8'h00;
    s.ch_after   = (gap_hi < DEPTH - 1) ? text_mem[gap_hi+1] : 8'h00;
    s.sel_active = sel_on;
    s.sel_start  = sel_from[5:0];
    s.sel_end    = sel_to[5:0];
    return s;
  endfunction

  function automatic int idle_len(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_cmd(gbte_func_t fn, logic [7:0] ch, logic [5:0] tgt, bit typed,
                          status_t want);
    int      g;
    status_t s;
    if ($urandom_range(0, 49) == 0) tx_steady = !tx_steady;
    g = idle_len(tx_steady);
    if (g > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, tgt, ch, fn};
    do @(posedge clk); while (!s_axis_tready);
    s = apply_command(fn, ch, tgt);
    status_q.push_back(typed ? want : s);
  endtask

  // hold tready low for random stalls
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall--;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 99) == 0) rx_steady = !rx_steady;
      if ($urandom_range(0, 3) == 0) rx_stall = idle_len(rx_steady);
    end
  end

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = status_t'(m_axis_tdata[41:0]);
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected status beat %h", got);
      end else begin
        want = status_q.pop_front();
        if (got.moved !== want.moved || got.cursor !== want.cursor ||
            got.text_len !== want.text_len || got.ch_before !== want.ch_before ||
            got.ch_after !== want.ch_after || got.sel_active !== want.sel_active ||
            got.sel_start !== want.sel_start || got.sel_end !== want.sel_end) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp mv=%0d cur=%0d len=%0d cb=%h ca=%h sel=%0d %0d..%0d",
                      " | got mv=%0d cur=%0d len=%0d cb=%h ca=%h sel=%0d %0d..%0d"},
                     want.moved, want.cursor, want.text_len, want.ch_before, want.ch_after,
                     want.sel_active, want.sel_start, want.sel_end,
                     got.moved, got.cursor, got.text_len, got.ch_before, got.ch_after,
                     got.sel_active, got.sel_start, got.sel_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int         r;
    int         len;
    int         ins_cut;
    gbte_func_t fn;
    logic [5:0] tgt;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    errors        = 0;
    cycles        = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    rx_stall      = 0;
    clear_editor();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i])
      for (int k = 0; k < script[i].reps; k++)
        send_cmd(script[i].fn, script[i].ch ^ 8'(k * 37), script[i].tgt, script[i].typed,
                 script[i].want);

    // favor inserts while the text is short, gotos once it is nearly full
    for (int n = 0; n < N_RANDOM; n++) begin
      len     = gap_lo + (DEPTH - 1 - gap_hi);
      ins_cut = (len > 56) ? 12 : 35;
      r       = $urandom_range(0, 99);
      if (r < ins_cut) fn = FN_INSERT;
      else if (r < ins_cut + 10) fn = FN_BACK;
      else if (r < ins_cut + 22) fn = FN_LEFT;
      else if (r < ins_cut + 34) fn = FN_RIGHT;
      else if (r < ins_cut + 44) fn = FN_SEL_LEFT;
      else if (r < ins_cut + 54) fn = FN_SEL_RIGHT;
      else if (r < ins_cut + 58) fn = FN_DESELECT;
      else fn = FN_GOTO;
      if ($urandom_range(0, 3) != 0) tgt = 6'($urandom_range(0, len));
      else tgt = 6'($urandom_range(0, 63));
      send_cmd(fn, 8'($urandom_range(0, 255)), tgt, 1'b0, '0);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
